@@ src/assert_macros.svh @@
// assertion macros shared by the stack modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lsi_pkg.sv @@
// shared types and constants of the lifo stack unit
`timescale 1ns / 1ps
`default_nettype none

package lsi_pkg;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_EXISTS = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
  localparam logic [OP_W-1:0] OP_CYCLIC = 3'd4;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic load_out;
  } lsi_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic scan_hit;
    logic scan_last;
  } lsi_stat_t;

endpackage

`default_nettype wire

@@ src/lsi_datapath.sv @@
// stack memory, count and iterator registers, search compare and result register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lsi_datapath
  import lsi_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lsi_cmd_t            cmd,
  output lsi_stat_t                stat,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [DATA_W-1:0]   in_value,
  output logic      [DATA_W-1:0]   out_data,
  output logic                     out_found,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [COUNT_W-1:0]  out_count
);

  // stored width: values are limited to the 32-bit field anyway
  localparam int SW = (ENTRY_WIDTH < DATA_W) ? ENTRY_WIDTH : DATA_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [SW-1:0] mem [CAPACITY];
  logic [SW-1:0] rd_data_r;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] iter_r, iter_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [SW-1:0] value_r, value_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic res_found_r, res_found_nxt;
  logic res_den_r, res_den_nxt;

  logic [DATA_W-1:0]   out_data_r;
  logic                out_found_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic          full;
  logic          push_ok;
  logic [CW-1:0] pop_idx, scan_inc, cyc_pos, cyc_inc;

  // flags and index arithmetic
  assign full      = (fill_r == CW'(CAPACITY));
  assign push_ok   = cmd.accept && (in_op == OP_PUSH) && !full;
  assign pop_idx   = fill_r - 1'b1;
  assign scan_inc  = scan_idx_r + 1'b1;
  assign cyc_pos   = (iter_r >= fill_r) ? '0 : iter_r;
  assign cyc_inc   = cyc_pos + 1'b1;

  assign stat.empty     = (fill_r == '0);
  assign stat.scan_hit  = (rd_data_r == value_r);
  assign stat.scan_last = (scan_inc >= fill_r);

  // operation decode
  always_comb begin
    fill_nxt       = fill_r;
    iter_nxt       = iter_r;
    scan_idx_nxt   = scan_idx_r;
    value_nxt      = value_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_den_nxt    = res_den_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = scan_inc[AW-1:0];
    if (cmd.accept) begin
      value_nxt      = SW'(in_value);
      res_status_nxt = ST_OK;
      res_found_nxt  = 1'b0;
      res_den_nxt    = 1'b0;
      scan_idx_nxt   = '0;
      case (in_op)
        OP_PUSH: begin
          if (!full) begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end else begin
            res_status_nxt = ST_FULL;
          end
        end
        OP_POP: begin
          if (stat.empty) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            fill_nxt    = pop_idx;
            rd_en       = 1'b1;
            rd_addr     = pop_idx[AW-1:0];
            res_den_nxt = 1'b1;
          end
        end
        OP_EXISTS: begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
        OP_NEXT: begin
          if (iter_r >= fill_r) begin
            iter_nxt       = '0;
            res_status_nxt = ST_EMPTY;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = iter_r[AW-1:0];
            iter_nxt    = iter_r + 1'b1;
            res_den_nxt = 1'b1;
          end
        end
        OP_CYCLIC: begin
          if (stat.empty) begin
            iter_nxt       = '0;
            res_status_nxt = ST_EMPTY;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = cyc_pos[AW-1:0];
            iter_nxt    = (cyc_inc >= fill_r) ? '0 : cyc_inc;
            res_den_nxt = 1'b1;
          end
        end
        OP_REWIND: begin
          iter_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.scan) begin
      // one entry compared per cycle, next one fetched meanwhile
      res_found_nxt = stat.scan_hit;
      rd_en         = 1'b1;
      scan_idx_nxt  = scan_inc;
    end
  end

  // stack memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= SW'(in_value);
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // count and iterator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      iter_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      iter_r <= iter_nxt;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_den_r    <= res_den_nxt;
    if (cmd.load_out) begin
      out_data_r   <= res_den_r ? DATA_W'(rd_data_r) : '0;
      out_found_r  <= res_found_r;
      out_status_r <= res_status_r;
      out_count_r  <= COUNT_W'(fill_r);
    end
  end

  assign out_data   = out_data_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  `LSI_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CW'(CAPACITY), "fill count beyond capacity")
  `LSI_ASSERT_NOW(a_scan_range, cmd.scan, scan_idx_r < fill_r, "scan index past fill count")
  `LSI_ASSERT_NEXT(a_push_grow, push_ok, fill_r == $past(fill_r) + 1'b1, "push did not grow")

endmodule

`default_nettype wire

@@ src/lsi_controller.sv @@
// controller state machine and output word handshake
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lsi_controller
  import lsi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [OP_W-1:0] in_op,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output lsi_cmd_t             cmd,
  input  wire lsi_stat_t       stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, out_free;

  // handshake
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign cmd.accept   = accept;
  assign cmd.scan     = (state_r == S_SCAN);
  assign cmd.load_out = (state_r == S_FIN) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == OP_EXISTS && !stat.empty) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `LSI_ASSERT_NEXT(a_accept_busy, accept, state_r != S_IDLE, "accepted word left controller idle")
  `LSI_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r, "stalled output word dropped")
  `LSI_ASSERT_NEXT(a_fin_wait, state_r == S_FIN && !out_free, state_r == S_FIN, "result not held")

endmodule

`default_nettype wire

@@ src/lifo_stack_with_search_and_iterator_unit.sv @@
// top level of the lifo stack with search and iterator
//
//   port group   direction   handshake            payload
//   in_          input       in_valid/in_stall    in_op, in_value
//   out_         output      out_valid/out_stall  out_data, out_found, out_status, out_count
//
// push, pop, iterate, cyclic iterate and rewind go from idle straight to the finish state
// exists scans until a hit or the last entry; the scan reads one memory entry per cycle
// the single-port stack memory and the controller handle one word at a time
// a new word is taken while the previous result waits in the output register
// synchronous reset empties the stack and rewinds the iterator; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_search_and_iterator_unit
  import lsi_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [DATA_W-1:0]   in_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [DATA_W-1:0]   out_data,
  output logic                     out_found,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [COUNT_W-1:0]  out_count
);

  lsi_cmd_t  cmd;
  lsi_stat_t stat;

  // sequencing
  lsi_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // storage and result
  lsi_datapath #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_data   (out_data),
    .out_found  (out_found),
    .out_status (out_status),
    .out_count  (out_count)
  );

endmodule

`default_nettype wire

@@ test/tb_lifo_stack_with_search_and_iterator_unit.sv @@
// testbench of the lifo stack unit: directed and random words against a shadow stack
`timescale 1ns / 1ps

module tb_lifo_stack_with_search_and_iterator_unit
  import lsi_pkg::*;
();

  localparam int CAPACITY    = 256;
  localparam int ENTRY_WIDTH = 32;
  localparam int DRAIN_CYCLES = CAPACITY + 40;

  // op codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [DATA_W-1:0]   data;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } stack_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_op = OP_PUSH;
  logic [DATA_W-1:0]   in_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DATA_W-1:0]   out_data;
  logic                out_found;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  // shadow copy of the stack contents and pointers
  logic [ENTRY_WIDTH-1:0] shadow_entries [CAPACITY];
  int unsigned            shadow_fill = 0;
  int unsigned            shadow_iter = 0;

  stack_result_t pending_results [$];
  int            error_count = 0;
  bit            idle_en = 1'b1;
  int            stall_left = 0;

  lifo_stack_with_search_and_iterator_unit #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .out_found  (out_found),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // clock
  always #4 clk = ~clk;

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // work out the result of one accepted word and update the shadow stack
  task automatic predict_stack_result(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    stack_result_t          r;
    logic [ENTRY_WIDTH-1:0] key;
    r.data   = '0;
    r.found  = 1'b0;
    r.status = ST_OK;
    key      = value[ENTRY_WIDTH-1:0];
    case (op)
      OP_PUSH: begin
        if (shadow_fill < CAPACITY) begin
          shadow_entries[shadow_fill] = key;
          shadow_fill++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_fill--;
          r.data[ENTRY_WIDTH-1:0] = shadow_entries[shadow_fill];
        end
      end
      OP_EXISTS: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_entries[i] == key) r.found = 1'b1;
        end
      end
      OP_NEXT: begin
        if (shadow_iter >= shadow_fill) begin
          shadow_iter = 0;
          r.status = ST_EMPTY;
        end else begin
          r.data[ENTRY_WIDTH-1:0] = shadow_entries[shadow_iter];
          shadow_iter++;
        end
      end
      OP_CYCLIC: begin
        if (shadow_fill == 0) begin
          shadow_iter = 0;
          r.status = ST_EMPTY;
        end else begin
          // a stale position wraps before the read
          if (shadow_iter >= shadow_fill) shadow_iter = 0;
          r.data[ENTRY_WIDTH-1:0] = shadow_entries[shadow_iter];
          shadow_iter++;
          if (shadow_iter >= shadow_fill) shadow_iter = 0;
        end
      end
      OP_REWIND: begin
        shadow_iter = 0;
      end
      default: begin
      end
    endcase
    r.count = shadow_fill[COUNT_W-1:0];
    pending_results.push_back(r);
  endtask

  // send one word, optionally after a short idle burst
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_stack_result(op, value);
  endtask

  // hold the input idle until every expected word has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // value: a small pool, a stored entry, or anything
  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 2);
    if (sel == 0) return DATA_W'($urandom_range(0, 7));
    if (sel == 1 && shadow_fill > 0)
      return DATA_W'(shadow_entries[$urandom_range(0, shadow_fill - 1)]);
    return $urandom;
  endfunction

  // one random word, push weight in percent
  task automatic send_random_word(input int push_weight);
    int               r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < push_weight) begin
      op = OP_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30)      op = OP_POP;
      else if (r < 52) op = OP_EXISTS;
      else if (r < 72) op = OP_NEXT;
      else if (r < 90) op = OP_CYCLIC;
      else if (r < 97) op = OP_REWIND;
      else             op = (r[0]) ? OP_SPARE_A : OP_SPARE_B;
    end
    send_word(op, pick_value());
  endtask

  // random words in blocks with a changing push bias
  task automatic run_random_blocks(input int blocks);
    int bias;
    repeat (blocks) begin
      case ($urandom_range(0, 2))
        0:       bias = 20;
        1:       bias = 45;
        default: bias = 75;
      endcase
      repeat (50) send_random_word(bias);
    end
  endtask

  // empty stack, extremes, every op, stale iterator positions, unused ops
  task automatic test_directed();
    send_word(OP_POP, 32'h0);
    send_word(OP_NEXT, 32'h0);
    send_word(OP_CYCLIC, 32'h0);
    send_word(OP_EXISTS, 32'h0);
    send_word(OP_PUSH, 32'h0000_0000);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_PUSH, 32'h1234_5678);
    send_word(OP_EXISTS, 32'hFFFF_FFFF);
    send_word(OP_EXISTS, 32'h0000_0000);
    send_word(OP_EXISTS, 32'h8765_4321);
    send_word(OP_NEXT, 32'hFFFF_FFFF);
    send_word(OP_NEXT, 32'h0);
    send_word(OP_NEXT, 32'h0);
    send_word(OP_NEXT, 32'h0);
    send_word(OP_CYCLIC, 32'h0);
    send_word(OP_CYCLIC, 32'h0);
    send_word(OP_NEXT, 32'h0);
    // iterator now beyond the count after the pop
    send_word(OP_POP, 32'h0);
    send_word(OP_CYCLIC, 32'h0);
    send_word(OP_NEXT, 32'h0);
    send_word(OP_POP, 32'h0);
    send_word(OP_NEXT, 32'h0);
    send_word(OP_REWIND, 32'hFFFF_FFFF);
    send_word(OP_SPARE_A, 32'hFFFF_FFFF);
    send_word(OP_SPARE_B, 32'hAAAA_5555);
    send_word(OP_CYCLIC, 32'h0);
  endtask

  // fill to capacity, push on full, scan a full stack, then drain to empty
  task automatic test_fill_and_drain();
    while (shadow_fill < CAPACITY) send_word(OP_PUSH, $urandom);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_PUSH, 32'h0);
    send_word(OP_EXISTS, DATA_W'(shadow_entries[CAPACITY-1]));
    send_word(OP_EXISTS, $urandom);
    send_word(OP_CYCLIC, 32'h0);
    // sender holds off until every result is back
    wait_drain();
    send_word(OP_EXISTS, DATA_W'(shadow_entries[0]));
    while (shadow_fill > 0) send_word(OP_POP, 32'h0);
    send_word(OP_POP, 32'h0);
  endtask

  // long random run with idling on both sides
  task automatic test_random_mix();
    run_random_blocks(18);
  endtask

  // random words with no idling on either side
  task automatic test_back_to_back();
    idle_en = 1'b0;
    run_random_blocks(4);
  endtask

  // result channel stall bursts
  always @(posedge clk) begin
    if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                             input logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $realtime, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    stack_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual data %h status %0d count %0d",
                 $realtime, out_data, out_status, out_count);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("data", exp_r.data, out_data);
        check_field("found", DATA_W'(exp_r.found), DATA_W'(out_found));
        check_field("status", DATA_W'(exp_r.status), DATA_W'(out_status));
        check_field("count", DATA_W'(exp_r.count), DATA_W'(out_count));
      end
    end
  end

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    test_back_to_back();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
